FILE: rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared widths, command and status codes for the canonical Huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int MAX_LEN_DEF     = 16;
  localparam int MAX_SYMBOLS_DEF = 512;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 9;
  localparam int VALUE_W  = 16;
  localparam int BOUND_W  = 10;
  localparam int SYM_W    = 16;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [LEN_W-1:0] CFG_LEN_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_LOAD_COUNT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SYMBOL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 2'd3;

  localparam logic [STATUS_W-1:0] ST_MORE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYMBOL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    code_length;
  } step_res_t;

endpackage

FILE: rtl/chd_step.sv
// ----------------------------------------------------------------------------
// chd_step
// One decode bit: shift the bit in, test the canonical range of this length.
// ----------------------------------------------------------------------------
module chd_step #(
  parameter int MAX_LEN     = chd_pkg::MAX_LEN_DEF,
  parameter int MAX_SYMBOLS = chd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic [MAX_LEN-1:0]                 acc,
  input  logic [MAX_LEN:0]                   first,
  input  logic [chd_pkg::LEN_W-1:0]          bits_taken,
  input  logic [chd_pkg::BOUND_W-1:0]        base,
  input  logic [chd_pkg::BOUND_W-1:0]        top,
  input  logic                               bit_in,
  input  logic [chd_pkg::LEN_W-1:0]          max_len_cfg,
  output chd_pkg::step_res_t                 res,
  output logic [$clog2(MAX_SYMBOLS)-1:0]     rd_addr,
  output logic [MAX_LEN-1:0]                 acc_nxt,
  output logic [MAX_LEN:0]                   first_nxt
);

  localparam int SYM_AW  = $clog2(MAX_SYMBOLS);
  localparam int FIRST_W = MAX_LEN + 1;
  localparam int W0      = (MAX_LEN > chd_pkg::BOUND_W) ? MAX_LEN : chd_pkg::BOUND_W;
  localparam int IDX_W   = ((W0 > SYM_AW) ? W0 : SYM_AW) + 1;

  logic [chd_pkg::LEN_W-1:0] len;
  logic [chd_pkg::LEN_W-1:0] n_used;
  logic [MAX_LEN:0]          code_wide;
  logic [MAX_LEN-1:0]        code;
  logic [IDX_W-1:0]          idx;
  logic [FIRST_W-1:0]        sum;
  logic                      below;
  logic                      hit;
  logic                      in_range;

  always_comb begin
    len       = bits_taken + chd_pkg::LEN_W'(1);
    if (max_len_cfg == '0) begin
      n_used = chd_pkg::LEN_W'(1);
    end else if (32'(max_len_cfg) > 32'(MAX_LEN)) begin
      n_used = chd_pkg::LEN_W'(MAX_LEN);
    end else begin
      n_used = max_len_cfg;
    end
    code_wide = {acc, bit_in};
    code      = code_wide[MAX_LEN-1:0];
    below     = FIRST_W'(code) < first;
    idx       = IDX_W'(code) - IDX_W'(first) + IDX_W'(base);
    hit       = idx < IDX_W'(top);
    in_range  = idx < IDX_W'(MAX_SYMBOLS);

    res.code_length = len;
    if (below) begin
      res.status = chd_pkg::ST_INVALID;
    end else if (hit) begin
      res.status = in_range ? chd_pkg::ST_SYMBOL : chd_pkg::ST_INVALID;
    end else if (len >= n_used) begin
      res.status = chd_pkg::ST_INVALID;
    end else begin
      res.status = chd_pkg::ST_MORE;
    end

    // start code of the next length: (first + count) << 1
    sum       = first + FIRST_W'(top) - FIRST_W'(base);
    first_nxt = {sum[FIRST_W-2:0], 1'b0};
    acc_nxt   = code;
    rd_addr   = idx[SYM_AW-1:0];
  end

endmodule

FILE: rtl/canonical_huffman_bit_decoder.sv
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder
// Bit-serial canonical Huffman decoder with loadable count and symbol tables.
// ----------------------------------------------------------------------------
// Takes one item per clock in any mix of commands (count loads, symbol loads,
// decode bits, accumulator clears); decode bits stall while a result is held.
// Each decode bit yields one result item via the input register, then the result
// register, which also captures the symbol memory's registered read. The per-bit
// work - shift, subtract, compare against the cumulative bound - fits between
// those registers, so the next bit can follow immediately. The bound table lives
// in flip-flops; the symbol table is a single-port-write, registered-read memory.
// Neither table is cleared: decode only through entries that were loaded.
// max_code_length must be written on the cfg channel only while the block is
// idle; the block does not enforce it. 0 counts as 1, above MAX_LEN as MAX_LEN.
// ----------------------------------------------------------------------------
module canonical_huffman_bit_decoder #(
  parameter int MAX_LEN     = chd_pkg::MAX_LEN_DEF,
  parameter int MAX_SYMBOLS = chd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config: max_code_length
  input  logic                               cfg_tvalid,
  output logic                               cfg_tready,
  input  logic [chd_pkg::LEN_W-1:0]          cfg_tdata,   // [4:0] max_code_length
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [chd_pkg::IN_DATA_W-1:0]      in_tdata,    // [8:0] slot, [24:9] value,
                                                          // [25] bit_req, [31:26] zero
  input  logic [chd_pkg::CMD_W-1:0]          in_tuser,    // [1:0] command
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [chd_pkg::OUT_DATA_W-1:0]     out_tdata,   // [15:0] symbol,
                                                          // [20:16] code_length, [23:21] zero
  output logic [chd_pkg::STATUS_W-1:0]       out_tuser    // [1:0] status
);

  localparam int BND_AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_AW     = $clog2(MAX_SYMBOLS);
  localparam int SLOT_EXT_W = (SYM_AW > chd_pkg::SLOT_W) ? SYM_AW : chd_pkg::SLOT_W;

  // configuration register
  logic [chd_pkg::LEN_W-1:0] max_len_r;

  // input register stage
  logic                          s1_v_r;
  logic [chd_pkg::CMD_W-1:0]     s1_cmd_r;
  logic [chd_pkg::SLOT_W-1:0]    s1_slot_r;
  logic [chd_pkg::VALUE_W-1:0]   s1_value_r;
  logic                          s1_bit_r;

  // decoder state
  logic [MAX_LEN-1:0]            acc_r;
  logic [MAX_LEN:0]              first_r;
  logic [chd_pkg::LEN_W-1:0]     bits_r;
  logic [chd_pkg::BOUND_W-1:0]   base_r;    // mirrors bound[bits_r-1], zero at bits_r 0

  // tables
  logic [chd_pkg::BOUND_W-1:0]   bound_r [MAX_LEN];
  logic [chd_pkg::SYM_W-1:0]     sym_mem [MAX_SYMBOLS];

  // result register
  logic                          out_v_r;
  logic [chd_pkg::STATUS_W-1:0]  out_status_r;
  logic [chd_pkg::LEN_W-1:0]     out_len_r;
  logic [chd_pkg::SYM_W-1:0]     sym_rd_r;

  // step datapath
  chd_pkg::step_res_t            res;
  logic [SYM_AW-1:0]             rd_addr;
  logic [MAX_LEN-1:0]            acc_nxt;
  logic [MAX_LEN:0]              first_nxt;
  logic [chd_pkg::BOUND_W-1:0]   top;

  logic                          out_free;
  logic                          s1_adv;
  logic                          is_decode;
  logic                          cnt_wr;
  logic                          sym_wr;
  logic [SLOT_EXT_W-1:0]         slot_ext;

  assign cfg_tready = 1'b1;

  // count the bits of the pending code; the bound of this length
  assign top       = bound_r[bits_r[BND_AW-1:0]];
  assign is_decode = s1_cmd_r == chd_pkg::CMD_DECODE;
  assign out_free  = !out_v_r || out_tready;
  // advance stage 1 unless a decode result has nowhere to go
  assign s1_adv    = s1_v_r && (!is_decode || out_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign slot_ext  = SLOT_EXT_W'(s1_slot_r);
  assign cnt_wr    = s1_adv && (s1_cmd_r == chd_pkg::CMD_LOAD_COUNT)
                     && (32'(s1_slot_r) < 32'(MAX_LEN));
  assign sym_wr    = s1_adv && (s1_cmd_r == chd_pkg::CMD_LOAD_SYMBOL)
                     && (32'(s1_slot_r) < 32'(MAX_SYMBOLS));

  chd_step #(
    .MAX_LEN     (MAX_LEN),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_step (
    .acc         (acc_r),
    .first       (first_r),
    .bits_taken  (bits_r),
    .base        (base_r),
    .top         (top),
    .bit_in      (s1_bit_r),
    .max_len_cfg (max_len_r),
    .res         (res),
    .rd_addr     (rd_addr),
    .acc_nxt     (acc_nxt),
    .first_nxt   (first_nxt)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= chd_pkg::CFG_LEN_RESET;
    end else if (cfg_tvalid && cfg_tready) begin
      max_len_r <= cfg_tdata;
    end
  end

  // input register: hold the item until stage 1 advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r   <= in_tuser;
      s1_slot_r  <= in_tdata[8:0];
      s1_value_r <= in_tdata[24:9];
      s1_bit_r   <= in_tdata[25];
    end
  end

  // decoder state: keep the partial code on "more", drop it otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      first_r <= '0;
      bits_r  <= '0;
      base_r  <= '0;
    end else if (s1_adv) begin
      case (s1_cmd_r)
        chd_pkg::CMD_DECODE: begin
          if (res.status == chd_pkg::ST_MORE) begin
            acc_r   <= acc_nxt;
            first_r <= first_nxt;
            bits_r  <= res.code_length;
            base_r  <= top;
          end else begin
            acc_r   <= '0;
            first_r <= '0;
            bits_r  <= '0;
            base_r  <= '0;
          end
        end
        chd_pkg::CMD_CLEAR: begin
          acc_r   <= '0;
          first_r <= '0;
          bits_r  <= '0;
          base_r  <= '0;
        end
        chd_pkg::CMD_LOAD_COUNT: begin
          // a reload of the previous length's bound mid-code updates the mirror
          if (cnt_wr && (bits_r != '0)
              && (s1_slot_r == chd_pkg::SLOT_W'(bits_r) - chd_pkg::SLOT_W'(1))) begin
            base_r <= s1_value_r[chd_pkg::BOUND_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // bound table
  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      bound_r[s1_slot_r[BND_AW-1:0]] <= s1_value_r[chd_pkg::BOUND_W-1:0];
    end
  end

  // symbol memory: write on load, registered read into the result stage
  always_ff @(posedge clk) begin
    if (sym_wr) begin
      sym_mem[slot_ext[SYM_AW-1:0]] <= s1_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && is_decode) begin
      sym_rd_r <= sym_mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_adv && is_decode;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && is_decode) begin
      out_status_r <= res.status;
      out_len_r    <= res.code_length;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_len_r,
                       (out_status_r == chd_pkg::ST_SYMBOL) ? sym_rd_r : '0};

endmodule

FILE: rtl/chd_checker.sv
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
module chd_checker #(
  parameter int MAX_LEN = chd_pkg::MAX_LEN_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [chd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [chd_pkg::STATUS_W-1:0]   out_tuser
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == chd_pkg::ST_MORE || out_tuser == chd_pkg::ST_SYMBOL
                    || out_tuser == chd_pkg::ST_INVALID))
    else $error("result status outside its codes");

  a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != chd_pkg::ST_SYMBOL) |-> (out_tdata[15:0] == 16'd0))
    else $error("symbol not zero on a non-symbol result");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[20:16] != 5'd0 && 32'(out_tdata[20:16]) <= 32'(MAX_LEN)))
    else $error("code length out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result item changed");

endmodule

bind canonical_huffman_bit_decoder chd_checker #(
  .MAX_LEN (MAX_LEN)
) u_chd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
